// ===== rtl/tsf_pkg.sv =====
// ----------------------------------------------------------------------------
// tsf_pkg
// Shared types and constants of the transport stream section filter.
// ----------------------------------------------------------------------------
package tsf_pkg;

  // Fixed field widths
  localparam int ADDR_W = 13;  // command address: store position or read index
  localparam int LEN_W  = 13;  // section length as reported
  localparam int CMP_W  = 14;  // fill counts and totals up to the largest store
  localparam int CFG_W  = 13;  // widest configuration register

  // Input op codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Result kinds on event_kind_o
  localparam logic [1:0] EVENT_COMPLETE = 2'd0;
  localparam logic [1:0] EVENT_DROPPED  = 2'd1;
  localparam logic [1:0] EVENT_READ     = 2'd2;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_FILTER_ENABLE   = 2'd0,
    REG_FILTER_PID      = 2'd1,
    REG_FILTER_TABLE_ID = 2'd2,
    REG_TABLE_ID_MASK   = 2'd3
  } cfg_reg_e;

  // Packet header layout
  localparam int  POS_HDR_PID_HI    = 1;
  localparam int  POS_HDR_PID_LO    = 2;
  localparam int  POS_CONT_PAYLOAD  = 4;  // first payload byte of a continuation packet
  localparam int  POS_START_PAYLOAD = 5;  // table id byte of a start packet
  localparam int  PUSI_BIT          = 6;
  localparam int  SECT_MIN_BYTES    = 4;
  localparam int  SECT_HDR_BYTES    = 3;
  localparam int  SECT_LEN_HI_POS   = 1;
  localparam int  SECT_LEN_LO_POS   = 2;

  // Queue depths
  localparam int CMD_QUEUE_DEPTH = 4;
  localparam int OUT_QUEUE_DEPTH = 4;

  // Work handed from the parser to the back end
  typedef enum logic [2:0] {
    EV_NONE,
    EV_COMPLETE,
    EV_DROP,
    EV_READ,
    EV_READ_OOR
  } ev_e;

  typedef struct packed {
    logic              wr;
    ev_e               ev;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic [7:0]        data;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [LEN_W-1:0] len;
    logic [7:0]       data;
  } res_t;

endpackage

// ===== rtl/tsf_fifo.sv =====
// ----------------------------------------------------------------------------
// tsf_fifo
// Small register queue with first-word fall-through read.
// ----------------------------------------------------------------------------
module tsf_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_en_i,
  input  logic [Width-1:0]           wr_data_i,
  input  logic                       rd_en_i,
  output logic [Width-1:0]           rd_data_o,
  output logic                       empty_o,
  output logic                       full_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth+1);

  logic [Width-1:0] slot_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (wr_en_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CntW'(wr_en_i) - CntW'(rd_en_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      slot_q[wr_ptr_q] <= wr_data_i;
    end
  end

  assign rd_data_o = slot_q[rd_ptr_q];
  assign empty_o   = (count_q == '0);
  assign full_o    = (count_q == CntW'(Depth));
  assign count_o   = count_q;

endmodule

// ===== rtl/tsf_front.sv =====
// ----------------------------------------------------------------------------
// tsf_front
// Packet parser and section filter: tracks the packet header, applies the
// PID and table id filter, counts section bytes and issues store writes,
// reads and events to the back end.
// ----------------------------------------------------------------------------
module tsf_front #(
  parameter int BUFFER_DEPTH = 4096,
  parameter int PACKET_BYTES = 188
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      item_valid_i,
  input  logic                      op_i,
  input  logic [7:0]                ts_byte_i,
  input  logic                      packet_start_i,
  input  logic [11:0]               read_index_i,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_index_i,
  input  logic [tsf_pkg::CFG_W-1:0] cfg_data_i,
  output logic                      cmd_valid_o,
  output tsf_pkg::cmd_t             cmd_o
);

  localparam int PosW      = $clog2(PACKET_BYTES + 1);
  localparam int FillW     = $clog2(BUFFER_DEPTH);
  localparam int CmpW      = tsf_pkg::CMP_W;
  localparam int PlenCont  = PACKET_BYTES - tsf_pkg::POS_CONT_PAYLOAD;
  localparam int PlenStart = PACKET_BYTES - tsf_pkg::POS_START_PAYLOAD;

  // Configuration
  logic        en_q;
  logic [12:0] fpid_q;
  logic [7:0]  ftid_q;
  logic [7:0]  mask_q;

  // Parser state
  logic [PosW-1:0]  pos_q, pos_d;
  logic             is_start_q, is_start_d;
  logic [12:0]      pid_q, pid_d;
  logic             sel_q, sel_d;
  logic [7:0]       lt_q, lt_d;
  logic             ltv_q, ltv_d;
  logic             coll_q, coll_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [3:0]       len_hi_q, len_hi_d;
  logic [7:0]       len_lo_q, len_lo_d;

  logic [PosW-1:0]  pos_eff;
  logic             store_en;
  logic [FillW-1:0] fill_base;
  logic [CmpW-1:0]  fill_inc;
  logic [CmpW-1:0]  need;
  logic [3:0]       hi_new;
  logic [7:0]       lo_new;
  logic             pid_hit;
  logic             match;
  tsf_pkg::cmd_t    cmd;

  assign pid_hit = (pid_q == fpid_q);

  always_comb begin
    pos_d      = pos_q;
    is_start_d = is_start_q;
    pid_d      = pid_q;
    sel_d      = sel_q;
    lt_d       = lt_q;
    ltv_d      = ltv_q;
    coll_d     = coll_q;
    fill_d     = fill_q;
    len_hi_d   = len_hi_q;
    len_lo_d   = len_lo_q;
    cmd        = '0;
    cmd.ev     = tsf_pkg::EV_NONE;
    store_en   = 1'b0;
    fill_base  = fill_q;
    match      = 1'b0;
    fill_inc   = '0;
    need       = '0;
    hi_new     = len_hi_q;
    lo_new     = len_lo_q;
    pos_eff    = packet_start_i ? '0 : pos_q;

    if (item_valid_i) begin
      if (op_i == tsf_pkg::OP_READ) begin
        cmd.ev   = (int'(read_index_i) < BUFFER_DEPTH) ? tsf_pkg::EV_READ
                                                       : tsf_pkg::EV_READ_OOR;
        cmd.addr = tsf_pkg::ADDR_W'(read_index_i);
      end else if (en_q) begin
        pos_d = pos_eff;
        if (pos_eff < PosW'(PACKET_BYTES)) begin
          pos_d = pos_eff + 1'b1;
          if (pos_eff == '0) begin
            sel_d = 1'b0;
          end else if (pos_eff == PosW'(tsf_pkg::POS_HDR_PID_HI)) begin
            is_start_d = ts_byte_i[tsf_pkg::PUSI_BIT];
            pid_d      = {ts_byte_i[4:0], 8'h00};
          end else if (pos_eff == PosW'(tsf_pkg::POS_HDR_PID_LO)) begin
            pid_d = {pid_q[12:8], ts_byte_i};
          end else if (pos_eff == PosW'(tsf_pkg::POS_CONT_PAYLOAD)) begin
            if (!is_start_q) begin
              match = pid_hit && ltv_q && ((lt_q & mask_q) == ftid_q);
              sel_d = match;
              if (match) begin
                if (!coll_q) begin
                  sel_d = 1'b0;
                end else if (CmpW'(fill_q) + CmpW'(PlenCont) >= CmpW'(BUFFER_DEPTH)) begin
                  coll_d = 1'b0;
                  fill_d = '0;
                  sel_d  = 1'b0;
                  cmd.ev = tsf_pkg::EV_DROP;
                end else begin
                  store_en = 1'b1;
                end
              end
            end
          end else if (pos_eff == PosW'(tsf_pkg::POS_START_PAYLOAD) && is_start_q) begin
            if (pid_hit) begin
              lt_d  = ts_byte_i;
              ltv_d = 1'b1;
            end
            match = pid_hit && ((ts_byte_i & mask_q) == ftid_q);
            sel_d = match;
            if (match) begin
              fill_base = '0;
              if (CmpW'(PlenStart) >= CmpW'(BUFFER_DEPTH)) begin
                coll_d = 1'b0;
                fill_d = '0;
                sel_d  = 1'b0;
                cmd.ev = tsf_pkg::EV_DROP;
              end else begin
                coll_d   = 1'b1;
                store_en = 1'b1;
              end
            end
          end else if (pos_eff > PosW'(tsf_pkg::POS_CONT_PAYLOAD) && sel_q) begin
            store_en = 1'b1;
          end
        end
      end
    end

    // Append one byte to the section; close it once the length is reached
    if (store_en) begin
      if (CmpW'(fill_base) >= CmpW'(BUFFER_DEPTH)) begin
        coll_d = 1'b0;
        fill_d = '0;
        sel_d  = 1'b0;
      end else begin
        cmd.wr   = 1'b1;
        cmd.addr = tsf_pkg::ADDR_W'(fill_base);
        cmd.data = ts_byte_i;
        if (fill_base == FillW'(tsf_pkg::SECT_LEN_HI_POS)) begin
          hi_new = ts_byte_i[3:0];
        end
        if (fill_base == FillW'(tsf_pkg::SECT_LEN_LO_POS)) begin
          lo_new = ts_byte_i;
        end
        len_hi_d = hi_new;
        len_lo_d = lo_new;
        fill_inc = CmpW'(fill_base) + 1'b1;
        need     = CmpW'({hi_new, lo_new}) + CmpW'(tsf_pkg::SECT_HDR_BYTES);
        if (fill_inc >= CmpW'(tsf_pkg::SECT_MIN_BYTES) && fill_inc >= need) begin
          fill_d  = '0;
          coll_d  = 1'b0;
          sel_d   = 1'b0;
          cmd.ev  = tsf_pkg::EV_COMPLETE;
          cmd.len = tsf_pkg::LEN_W'(need);
        end else begin
          fill_d = FillW'(fill_inc);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q       <= 1'b0;
      fpid_q     <= '0;
      ftid_q     <= '0;
      mask_q     <= 8'hFF;
      pos_q      <= PosW'(PACKET_BYTES);
      is_start_q <= 1'b0;
      pid_q      <= '0;
      sel_q      <= 1'b0;
      lt_q       <= '0;
      ltv_q      <= 1'b0;
      coll_q     <= 1'b0;
      fill_q     <= '0;
      len_hi_q   <= '0;
      len_lo_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          tsf_pkg::REG_FILTER_ENABLE:   en_q   <= cfg_data_i[0];
          tsf_pkg::REG_FILTER_PID:      fpid_q <= cfg_data_i[12:0];
          tsf_pkg::REG_FILTER_TABLE_ID: ftid_q <= cfg_data_i[7:0];
          tsf_pkg::REG_TABLE_ID_MASK:   mask_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      pos_q      <= pos_d;
      is_start_q <= is_start_d;
      pid_q      <= pid_d;
      sel_q      <= sel_d;
      lt_q       <= lt_d;
      ltv_q      <= ltv_d;
      coll_q     <= coll_d;
      fill_q     <= fill_d;
      len_hi_q   <= len_hi_d;
      len_lo_q   <= len_lo_d;
    end
  end

  assign cmd_o       = cmd;
  assign cmd_valid_o = cmd.wr || (cmd.ev != tsf_pkg::EV_NONE);

endmodule

// ===== rtl/tsf_back.sv =====
// ----------------------------------------------------------------------------
// tsf_back
// Back end: carries out store writes and reads in order, forms the result
// items and holds them in the output queue.
// ----------------------------------------------------------------------------
module tsf_back #(
  parameter int BUFFER_DEPTH = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  tsf_pkg::cmd_t              cmd_i,
  output logic                       cmd_pop_o,
  input  logic                       pop,
  output logic                       empty,
  output logic [1:0]                 event_kind_o,
  output logic [tsf_pkg::LEN_W-1:0]  section_length_o,
  output logic [7:0]                 read_data_o
);

  localparam int AddrW = $clog2(BUFFER_DEPTH);
  localparam int CntW  = $clog2(tsf_pkg::OUT_QUEUE_DEPTH + 1);

  logic [7:0] mem_q [BUFFER_DEPTH];
  logic [7:0] rdata_q;

  logic                      r_valid_q;
  tsf_pkg::ev_e              r_ev_q;
  logic [tsf_pkg::LEN_W-1:0] r_len_q;

  logic            issue;
  logic            has_result;
  logic            out_space;
  logic [CntW-1:0] out_count;
  logic            out_full;
  tsf_pkg::res_t   res;
  tsf_pkg::res_t   head;

  // Hold a result command until the output queue has room for it
  assign has_result = (cmd_i.ev != tsf_pkg::EV_NONE);
  assign out_space  = (CntW'(out_count) + CntW'(r_valid_q)) < CntW'(tsf_pkg::OUT_QUEUE_DEPTH);
  assign issue      = cmd_valid_i && (!has_result || out_space);
  assign cmd_pop_o  = issue;

  always_ff @(posedge clk_i) begin
    if (issue && cmd_i.wr) begin
      mem_q[cmd_i.addr[AddrW-1:0]] <= cmd_i.data;
    end
    if (issue && cmd_i.ev == tsf_pkg::EV_READ) begin
      rdata_q <= mem_q[cmd_i.addr[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
    end else begin
      r_valid_q <= issue && has_result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      r_ev_q  <= cmd_i.ev;
      r_len_q <= cmd_i.len;
    end
  end

  always_comb begin
    res = '0;
    case (r_ev_q)
      tsf_pkg::EV_COMPLETE: begin
        res.kind = tsf_pkg::EVENT_COMPLETE;
        res.len  = r_len_q;
      end
      tsf_pkg::EV_DROP:     res.kind = tsf_pkg::EVENT_DROPPED;
      tsf_pkg::EV_READ: begin
        res.kind = tsf_pkg::EVENT_READ;
        res.data = rdata_q;
      end
      tsf_pkg::EV_READ_OOR: res.kind = tsf_pkg::EVENT_READ;
      default: ;
    endcase
  end

  tsf_fifo #(
    .Width ($bits(tsf_pkg::res_t)),
    .Depth (tsf_pkg::OUT_QUEUE_DEPTH)
  ) u_out_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (r_valid_q),
    .wr_data_i (res),
    .rd_en_i   (pop && !empty),
    .rd_data_o (head),
    .empty_o   (empty),
    .full_o    (out_full),
    .count_o   (out_count)
  );

  assign event_kind_o     = head.kind;
  assign section_length_o = out_full ? head.len : head.len;
  assign read_data_o      = head.data;

endmodule

// ===== rtl/ts_section_filter_assembler.sv =====
// ----------------------------------------------------------------------------
// ts_section_filter_assembler
// Section filter for a byte-serial transport stream: selects packets by PID
// and masked table id, assembles sections in a byte store and reports them;
// read ops return store bytes.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  input     push / full          op_i, ts_byte_i, packet_start_i, read_index_i
//  result    empty / pop          event_kind_o, section_length_o, read_data_o
//  config    cfg_we_i (no wait)   cfg_index_i, cfg_data_i
//
//  One item per cycle while full is low; the parser updates all packet state in the
//  cycle it takes a byte. A result passes through the command queue, the store read
//  register and the output queue to the outputs. The single store port is shared
//  by byte writes and reads in item order.
//  Reset clears the parser and queues at once; store contents are undefined.
//  full rises only when the command queue backs up behind a stalled result side.
// ----------------------------------------------------------------------------
module ts_section_filter_assembler #(
  parameter int BUFFER_DEPTH = 4096,
  parameter int PACKET_BYTES = 188
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic                      op_i,
  input  logic [7:0]                ts_byte_i,
  input  logic                      packet_start_i,
  input  logic [11:0]               read_index_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [1:0]                event_kind_o,
  output logic [12:0]               section_length_o,
  output logic [7:0]                read_data_o,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_index_i,
  input  logic [tsf_pkg::CFG_W-1:0] cfg_data_i
);

  logic          front_valid;
  tsf_pkg::cmd_t front_cmd;
  logic          cmd_empty;
  logic          cmd_pop;
  tsf_pkg::cmd_t cmd_head;

  tsf_front #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .PACKET_BYTES (PACKET_BYTES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (push && !full),
    .op_i           (op_i),
    .ts_byte_i      (ts_byte_i),
    .packet_start_i (packet_start_i),
    .read_index_i   (read_index_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_valid_o    (front_valid),
    .cmd_o          (front_cmd)
  );

  tsf_fifo #(
    .Width ($bits(tsf_pkg::cmd_t)),
    .Depth (tsf_pkg::CMD_QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (front_valid),
    .wr_data_i (front_cmd),
    .rd_en_i   (cmd_pop),
    .rd_data_o (cmd_head),
    .empty_o   (cmd_empty),
    .full_o    (full),
    .count_o   ()
  );

  tsf_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (!cmd_empty),
    .cmd_i            (cmd_head),
    .cmd_pop_o        (cmd_pop),
    .pop              (pop),
    .empty            (empty),
    .event_kind_o     (event_kind_o),
    .section_length_o (section_length_o),
    .read_data_o      (read_data_o)
  );

endmodule

// ===== rtl/tsf_checker.sv =====
// ----------------------------------------------------------------------------
// tsf_checker
// Port-level checks of the section filter result stream.
// ----------------------------------------------------------------------------
module tsf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  event_kind_o,
  input logic [12:0] section_length_o,
  input logic [7:0]  read_data_o
);

  // Only the three defined result kinds appear
  a_kind_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (event_kind_o == tsf_pkg::EVENT_COMPLETE ||
                event_kind_o == tsf_pkg::EVENT_DROPPED ||
                event_kind_o == tsf_pkg::EVENT_READ))
    else $error("tsf: undefined result kind");

  // A completed section spans at least its header and at most a full length
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && event_kind_o == tsf_pkg::EVENT_COMPLETE) |->
      (section_length_o >= 13'd3 && section_length_o <= 13'd4098))
    else $error("tsf: section length out of range");

  // Fields that do not belong to a kind read as zero
  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && event_kind_o != tsf_pkg::EVENT_READ) |-> read_data_o == 8'd0)
    else $error("tsf: read data on a section event");

  a_read_no_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && event_kind_o != tsf_pkg::EVENT_COMPLETE) |-> section_length_o == 13'd0)
    else $error("tsf: length on a non-section result");

  // Hold the head result until transfer
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(event_kind_o) &&
                          $stable(section_length_o) && $stable(read_data_o)))
    else $error("tsf: waiting result changed");

endmodule

bind ts_section_filter_assembler tsf_checker u_tsf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .empty            (empty),
  .pop              (pop),
  .event_kind_o     (event_kind_o),
  .section_length_o (section_length_o),
  .read_data_o      (read_data_o)
);
